[hw/rtl/upe_pkg.sv]
package upe_pkg;

	// Register and stream field widths
	localparam int unsigned CP_W    = 21;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned RUN_MAX = 12;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned HELD_W  = 10;

	// encoding_mode codes
	localparam logic [MODE_W-1:0] MODE_SPACES    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FORM      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ESCAPE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_URI       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_URI_COMP  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RESET     = MODE_URI;

	// Surrogate bounds
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI_END = 21'h00DC00;
	localparam logic [CP_W-1:0] SURR_LAST   = 21'h00DFFF;
	localparam logic [CP_W-1:0] SUPP_BASE   = 21'h010000;

	// ASCII characters that the encoder emits
	localparam logic [CP_W-1:0] CH_PCT   = 21'h25;
	localparam logic [CP_W-1:0] CH_U     = 21'h75;
	localparam logic [CP_W-1:0] CH_PLUS  = 21'h2B;
	localparam logic [CP_W-1:0] CH_SPACE = 21'h20;
	localparam logic [CP_W-1:0] CH_TWO   = 21'h32;
	localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;

	// One expanded run plus the surrogate state it leaves behind
	typedef struct packed {
		logic [RUN_MAX-1:0][CP_W-1:0] chars;
		logic [CNT_W-1:0]             cnt;
		logic                         err;
		logic                         held_valid_nxt;
		logic [HELD_W-1:0]            held_bits_nxt;
	} run_t;

	// Uppercase hex digit for a nibble
	function automatic logic [CP_W-1:0] hex_digit(input logic [3:0] v);
		logic [CP_W-1:0] w;
		w = {17'd0, v};
		return (v < 4'd10) ? (21'h30 + w) : (21'h37 + w);
	endfunction

	function automatic logic is_alnum(input logic [CP_W-1:0] c);
		return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
		       (c >= 21'h30 && c <= 21'h39);
	endfunction

	// alnum and - _ . ! ~ * ' ( )
	function automatic logic in_comp_set(input logic [CP_W-1:0] c);
		return is_alnum(c) || c == 21'h2D || c == 21'h5F || c == 21'h2E ||
		       c == 21'h21 || c == 21'h7E || c == 21'h2A || c == 21'h27 ||
		       c == 21'h28 || c == 21'h29;
	endfunction

	// component set plus ; / ? : @ & = + $ , #
	function automatic logic in_uri_set(input logic [CP_W-1:0] c);
		return in_comp_set(c) || c == 21'h3B || c == 21'h2F || c == 21'h3F ||
		       c == 21'h3A || c == 21'h40 || c == 21'h26 || c == 21'h3D ||
		       c == 21'h2B || c == 21'h24 || c == 21'h2C || c == 21'h23;
	endfunction

endpackage

[hw/rtl/upe_ifs.sv]
// Input stream: one code point per transaction
interface upe_in_if;
	import upe_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            last_in_string;

	modport source (output valid, output code_point, output last_in_string, input ready);
	modport sink   (input valid, input code_point, input last_in_string, output ready);
endinterface

// Output stream: one emitted character per transaction
interface upe_out_if;
	import upe_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] out_char;
	logic            last_of_run;
	logic            encode_error;

	modport source (output valid, output out_char, output last_of_run, output encode_error,
		input ready);
	modport sink   (input valid, input out_char, input last_of_run, input encode_error,
		output ready);
endinterface

[hw/rtl/upe_expand.sv]
module upe_expand (
	input  logic [upe_pkg::MODE_W-1:0] mode,
	input  logic [upe_pkg::CP_W-1:0]   code_point,
	input  logic                       last_in_string,
	input  logic                       held_valid,
	input  logic [upe_pkg::HELD_W-1:0] held_bits,
	output upe_pkg::run_t              run
);
	import upe_pkg::*;

	logic            is_uri;
	logic            is_fe;
	logic            in_set;
	logic            is_surr;
	logic [CP_W-1:0] supp_cp;
	logic [CP_W-1:0] enc_cp;
	logic [3:0][7:0] oct;
	logic [2:0]      noct;
	logic [5:0][3:0] nib;
	logic [2:0]      digits;
	logic [2:0]      nsel;
	logic            pass_fe;

	// Mode decode and character classes
	always_comb begin
		is_uri  = (mode == MODE_URI) || (mode == MODE_URI_COMP);
		is_fe   = (mode == MODE_FORM) || (mode == MODE_ESCAPE);
		in_set  = (mode == MODE_URI) ? in_uri_set(code_point) : in_comp_set(code_point);
		is_surr = (code_point >= SURR_LO) && (code_point <= SURR_LAST);
		supp_cp = {1'b0, held_bits, code_point[9:0]} + SUPP_BASE;
		pass_fe = is_alnum(code_point) ||
			((mode == MODE_FORM) && (code_point == 21'h2D || code_point == 21'h5F ||
				code_point == 21'h2E || code_point == 21'h7E)) ||
			((mode == MODE_ESCAPE) && (code_point == 21'h40 || code_point == 21'h2D ||
				code_point == 21'h5F || code_point == 21'h2E || code_point == 21'h2A ||
				code_point == 21'h2B || code_point == 21'h2F));
	end

	// UTF-8 octets of the value to encode (form and escape modes use one raw octet)
	always_comb begin
		enc_cp = held_valid ? supp_cp : code_point;
		oct    = '0;
		noct   = 3'd1;
		if (is_fe || enc_cp < 21'h80) begin
			oct[0] = enc_cp[7:0];
			noct   = 3'd1;
		end else if (enc_cp < 21'h800) begin
			oct[0] = {3'b110, enc_cp[10:6]};
			oct[1] = {2'b10, enc_cp[5:0]};
			noct   = 3'd2;
		end else if (enc_cp < 21'h10000) begin
			oct[0] = {4'b1110, enc_cp[15:12]};
			oct[1] = {2'b10, enc_cp[11:6]};
			oct[2] = {2'b10, enc_cp[5:0]};
			noct   = 3'd3;
		end else begin
			oct[0] = {5'b11110, enc_cp[20:18]};
			oct[1] = {2'b10, enc_cp[17:12]};
			oct[2] = {2'b10, enc_cp[11:6]};
			oct[3] = {2'b10, enc_cp[5:0]};
			noct   = 3'd4;
		end
	end

	// Nibbles for the %u form
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			nib[k] = code_point[4*k +: 4];
		end
		nib[5] = {3'b000, code_point[20]};
		if (code_point > 21'hFFFFF) begin
			digits = 3'd6;
		end else if (code_point > 21'hFFFF) begin
			digits = 3'd5;
		end else begin
			digits = 3'd4;
		end
	end

	// Build the run
	always_comb begin
		run                = '0;
		run.held_valid_nxt = held_valid;
		run.held_bits_nxt  = held_bits;
		nsel               = 3'd0;
		if (is_uri) begin
			run.held_valid_nxt = 1'b0;
			run.held_bits_nxt  = '0;
			if (held_valid && (code_point < SURR_HI_END || code_point > SURR_LAST)) begin
				// mismatched follower
				run.err = 1'b1;
				run.cnt = 4'd1;
			end else if (!held_valid && in_set) begin
				run.chars[0] = code_point;
				run.cnt      = 4'd1;
			end else if (!held_valid && is_surr) begin
				if (code_point >= SURR_HI_END || last_in_string) begin
					// lone low surrogate, or high surrogate at end of string
					run.err = 1'b1;
					run.cnt = 4'd1;
				end else begin
					run.held_valid_nxt = 1'b1;
					run.held_bits_nxt  = code_point[9:0];
				end
			end else begin
				for (int i = 0; i < 4; i++) begin
					run.chars[3*i]   = CH_PCT;
					run.chars[3*i+1] = hex_digit(oct[i][7:4]);
					run.chars[3*i+2] = hex_digit(oct[i][3:0]);
				end
				run.cnt = {noct[1:0], 2'b00} - {1'b0, noct};
			end
		end else if (is_fe) begin
			if (pass_fe) begin
				run.chars[0] = code_point;
				run.cnt      = 4'd1;
			end else if (mode == MODE_FORM && code_point == CH_SPACE) begin
				run.chars[0] = CH_PLUS;
				run.cnt      = 4'd1;
			end else if (code_point < 21'h100) begin
				run.chars[0] = CH_PCT;
				run.chars[1] = hex_digit(oct[0][7:4]);
				run.chars[2] = hex_digit(oct[0][3:0]);
				run.cnt      = 4'd3;
			end else begin
				run.chars[0] = CH_PCT;
				run.chars[1] = CH_U;
				for (int j = 0; j < 6; j++) begin
					nsel = digits - 3'(j) - 3'd1;
					if (3'(j) < digits) begin
						run.chars[2+j] = hex_digit(nib[nsel]);
					end
				end
				run.cnt = {1'b0, digits} + 4'd2;
			end
		end else begin
			// spaces mode, also the undefined codes
			if (code_point == CH_SPACE) begin
				run.chars[0] = CH_PCT;
				run.chars[1] = CH_TWO;
				run.chars[2] = CH_ZERO;
				run.cnt      = 4'd3;
			end else begin
				run.chars[0] = code_point;
				run.cnt      = 4'd1;
			end
		end
	end

endmodule

[hw/rtl/url_percent_encoder.sv]
// Percent encoder for a stream of Unicode code points. Each input transaction carries one
// code point and expands into a run of 1 to 12 output characters (none while a high
// surrogate waits for its partner in the URI modes); the final character of a run has
// last_of_run set, and an invalid surrogate sequence gives a single error transaction with
// out_char zero. An input item sits in one input register while its run drains through the
// output register, one character per cycle while out_ch is ready; a new item is taken only
// as the current run completes. Unescaped text flows at one item per cycle unless out_ch stalls.
// The user must write the mode register (reset: URI) only while the stream is idle; the block
// itself does not enforce this. A write drops any held surrogate.
module url_percent_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [upe_pkg::MODE_W-1:0] cfg_wdata,
	upe_in_if.sink                     in_ch,
	upe_out_if.source                  out_ch
);
	import upe_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              held_valid_q;
	logic [HELD_W-1:0] held_bits_q;

	logic              valid_s1;
	logic [CP_W-1:0]   cp_s1;
	logic              last_s1;
	logic [CNT_W-1:0]  idx_q;

	logic              out_valid_q;
	logic [CP_W-1:0]   out_char_q;
	logic              out_last_q;
	logic              out_err_q;

	run_t              run;
	logic              load_ok;
	logic              emit;
	logic              done;
	logic              in_take;

	// Expansion of the item in the input register
	upe_expand u_expand (
		.mode           (mode_q),
		.code_point     (cp_s1),
		.last_in_string (last_s1),
		.held_valid     (held_valid_q),
		.held_bits      (held_bits_q),
		.run            (run)
	);

	// Handshake control
	always_comb begin
		load_ok     = !out_valid_q || out_ch.ready;
		emit        = valid_s1 && (run.cnt != '0) && load_ok;
		done        = valid_s1 && ((run.cnt == '0) || (emit && (idx_q == run.cnt - 4'd1)));
		in_ch.ready = !valid_s1 || done;
		in_take     = in_ch.valid && in_ch.ready;
	end

	// Mode register and surrogate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RESET;
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (cfg_we) begin
			mode_q       <= cfg_wdata;
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (done) begin
			held_valid_q <= run.held_valid_nxt;
			held_bits_q  <= run.held_bits_nxt;
		end
	end

	// Input register and run index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cp_s1   <= in_ch.code_point;
			last_s1 <= in_ch.last_in_string;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= run.chars[idx_q];
			out_last_q <= (idx_q == run.cnt - 4'd1);
			out_err_q  <= run.err;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_char     = out_char_q;
	assign out_ch.last_of_run  = out_last_q;
	assign out_ch.encode_error = out_err_q;

	// Error transactions are single, zero-valued and close their run
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.encode_error |-> out_ch.last_of_run && out_ch.out_char == '0)
		else $error("error transaction malformed");

	// Run index stays inside the current run
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && run.cnt != '0 |-> idx_q < run.cnt)
		else $error("run index past run length");

	// A surrogate is held only in the URI modes
	a_held_mode: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (mode_q == MODE_URI || mode_q == MODE_URI_COMP))
		else $error("surrogate held outside URI modes");

	// A mode write drops the held surrogate
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !held_valid_q)
		else $error("held surrogate survived mode write");

endmodule

[test/tb_top.sv]
module tb_top;
	import upe_pkg::*;

	localparam int unsigned LIMIT_CYC   = 2_000_000;
	localparam int unsigned DRAIN_CYC   = 16;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam int unsigned MAX_PRINT   = 40;
	localparam int unsigned NUM_PHASES  = 9;

	// encoding_mode value outside the defined range; decodes as spaces mode
	localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;

	localparam logic [CP_W-1:0] ASC_A = 21'h41;

	typedef struct {
		logic [CP_W-1:0] cp;
		logic            last;
	} src_item_t;

	typedef struct {
		logic [CP_W-1:0] ch;
		logic            run_end;
		logic            err;
	} enc_char_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_we    = 1'b0;
	logic [MODE_W-1:0] cfg_wdata = '0;

	// Driven stream signals, known from time zero
	logic            drv_valid = 1'b0;
	logic [CP_W-1:0] drv_cp    = '0;
	logic            drv_last  = 1'b0;
	logic            drv_ready = 1'b0;

	upe_in_if  in_bus ();
	upe_out_if out_bus ();

	assign in_bus.valid          = drv_valid;
	assign in_bus.code_point     = drv_cp;
	assign in_bus.last_in_string = drv_last;
	assign out_bus.ready         = drv_ready;

	url_percent_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	src_item_t src_q[$];
	enc_char_t char_q[$];

	// Encoder model state
	logic [MODE_W-1:0] enc_mode      = MODE_RESET;
	logic [HELD_W-1:0] enc_held_bits = '0;
	logic              enc_held      = 1'b0;

	int unsigned cyc     = 0;
	int unsigned err_cnt = 0;
	logic        in_hs   = 1'b0;
	int          in_gap    = 0;
	int          out_stall = 0;
	int          calm_in   = 0;
	int          calm_out  = 0;

	// ---------------------------------------------------------------- encoder model

	function automatic logic [CP_W-1:0] hex_ascii(input logic [3:0] v);
		return (v < 4'd10) ? (CH_ZERO + CP_W'(v)) : (ASC_A + CP_W'(v) - 21'd10);
	endfunction

	function automatic logic alnum(input logic [CP_W-1:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
	endfunction

	function automatic logic comp_plain(input logic [CP_W-1:0] c);
		return alnum(c) || c == "-" || c == "_" || c == "." || c == "!" || c == "~" ||
		       c == "*" || c == "'" || c == "(" || c == ")";
	endfunction

	function automatic logic uri_plain(input logic [CP_W-1:0] c);
		return comp_plain(c) || c == ";" || c == "/" || c == "?" || c == ":" || c == "@" ||
		       c == "&" || c == "=" || c == "+" || c == "$" || c == "," || c == "#";
	endfunction

	function automatic void put_char(input logic [CP_W-1:0] ch, input logic err);
		enc_char_t e;
		e.ch      = ch;
		e.run_end = err;
		e.err     = err;
		char_q.insert(char_q.size(), e);
	endfunction

	function automatic void put_octet(input logic [7:0] o);
		put_char(CH_PCT, 1'b0);
		put_char(hex_ascii(o[7:4]), 1'b0);
		put_char(hex_ascii(o[3:0]), 1'b0);
	endfunction

	function automatic void put_utf8(input logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			put_octet(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_octet({3'b110, cp[10:6]});
			put_octet({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_octet({4'b1110, cp[15:12]});
			put_octet({2'b10, cp[11:6]});
			put_octet({2'b10, cp[5:0]});
		end else begin
			put_octet({5'b11110, cp[20:18]});
			put_octet({2'b10, cp[17:12]});
			put_octet({2'b10, cp[11:6]});
			put_octet({2'b10, cp[5:0]});
		end
	endfunction

	// %XX below 256, else %u with four to six digits
	function automatic void put_uescape(input logic [CP_W-1:0] cp);
		int ndig;
		int k;
		if (cp < 21'h100) begin
			put_octet(cp[7:0]);
		end else begin
			ndig = (cp > 21'hFFFFF) ? 6 : (cp > 21'hFFFF) ? 5 : 4;
			put_char(CH_PCT, 1'b0);
			put_char(CH_U, 1'b0);
			for (k = ndig - 1; k >= 0; k--)
				put_char(hex_ascii(4'(cp >> (4 * k))), 1'b0);
		end
	endfunction

	// Expected run for one accepted code point
	function automatic void predict_run(input logic [CP_W-1:0] cp, input logic last);
		int        first;
		logic      keep;
		logic [HELD_W-1:0] hb;
		first = char_q.size();
		if (enc_mode == MODE_URI || enc_mode == MODE_URI_COMP) begin
			keep = (enc_mode == MODE_URI) ? uri_plain(cp) : comp_plain(cp);
			if (enc_held) begin
				// follower of a held high surrogate must be a low surrogate
				hb            = enc_held_bits;
				enc_held      = 1'b0;
				enc_held_bits = '0;
				if (cp < SURR_HI_END || cp > SURR_LAST) begin
					put_char('0, 1'b1);
					return;
				end
				put_utf8(SUPP_BASE + {1'b0, hb, 10'd0} + (cp - SURR_HI_END));
			end else if (keep) begin
				put_char(cp, 1'b0);
			end else if (cp >= SURR_LO && cp <= SURR_LAST) begin
				if (cp >= SURR_HI_END || last) begin
					put_char('0, 1'b1);
					return;
				end
				enc_held_bits = cp[HELD_W-1:0];
				enc_held      = 1'b1;
				return;
			end else begin
				put_utf8(cp);
			end
		end else if (enc_mode == MODE_FORM || enc_mode == MODE_ESCAPE) begin
			if (alnum(cp))
				put_char(cp, 1'b0);
			else if (enc_mode == MODE_FORM && (cp == "-" || cp == "_" || cp == "." || cp == "~"))
				put_char(cp, 1'b0);
			else if (enc_mode == MODE_FORM && cp == CH_SPACE)
				put_char(CH_PLUS, 1'b0);
			else if (enc_mode == MODE_ESCAPE && (cp == "@" || cp == "-" || cp == "_" ||
			         cp == "." || cp == "*" || cp == "+" || cp == "/"))
				put_char(cp, 1'b0);
			else
				put_uescape(cp);
		end else begin
			// spaces mode, also any undefined mode value
			if (cp == CH_SPACE) begin
				put_char(CH_PCT, 1'b0);
				put_char(CH_TWO, 1'b0);
				put_char(CH_ZERO, 1'b0);
			end else begin
				put_char(cp, 1'b0);
			end
		end
		// mark the final character of the run
		if (char_q.size() > first)
			char_q[char_q.size() - 1].run_end = 1'b1;
	endfunction

	// ---------------------------------------------------------------- helpers

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINT)
			$display("[cycle %0d] %s", cyc, msg);
	endtask

	// Idle length: mostly zero or short, a few long, with calm stretches
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3)
			calm = $urandom_range(60, 20);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(8, 4);
		return $urandom_range(40, 15);
	endfunction

	task automatic queue_item(input logic [CP_W-1:0] cp, input logic last);
		src_item_t it;
		it.cp   = cp;
		it.last = last;
		src_q.insert(src_q.size(), it);
	endtask

	// Random text: mostly plain characters and well-formed pairs, some broken sequences
	task automatic queue_random(input int n);
		int   cnt;
		int   r;
		logic lst;
		logic [CP_W-1:0] hi;
		cnt = 0;
		while (cnt < n) begin
			r   = $urandom_range(99);
			lst = ($urandom_range(7) == 0);
			hi  = CP_W'($urandom_range(21'hDBFF, 21'hD800));
			if (r < 38) begin
				queue_item(CP_W'($urandom_range(127)), lst);
			end else if (r < 44) begin
				queue_item(CH_SPACE, lst);
			end else if (r < 52) begin
				queue_item(CP_W'($urandom_range(21'h7FF, 21'h80)), lst);
			end else if (r < 62) begin
				queue_item(CP_W'($urandom_range(21'hFFFF, 21'h800)), lst);
			end else if (r < 67) begin
				queue_item(CP_W'($urandom_range(21'h10FFFF, 21'h10000)), lst);
			end else if (r < 70) begin
				queue_item(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), lst);
			end else if (r < 86) begin
				queue_item(hi, 1'b0);
				queue_item(CP_W'($urandom_range(21'hDFFF, 21'hDC00)), lst);
				cnt++;
			end else if (r < 92) begin
				// high surrogate followed by something that is not a low surrogate
				queue_item(hi, 1'b0);
				case ($urandom_range(2))
					0: queue_item(CP_W'($urandom_range(127)), lst);
					1: queue_item(CP_W'($urandom_range(21'hDBFF, 21'hD800)), lst);
					default: queue_item(CP_W'($urandom_range(21'h1FFFFF, 21'hE000)), lst);
				endcase
				cnt++;
			end else if (r < 96) begin
				queue_item(CP_W'($urandom_range(21'hDFFF, 21'hDC00)), lst);
			end else begin
				queue_item(hi, 1'b1);
			end
			cnt++;
		end
	endtask

	// Wait until every item is taken and every run has drained
	task automatic settle();
		while (src_q.size() != 0 || drv_valid || char_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin : drv
		src_item_t it;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (drv_valid && !in_hs) begin
			// hold the current transaction until it is taken
		end else if (in_gap > 0) begin
			drv_valid <= 1'b0;
			in_gap--;
		end else if (src_q.size() != 0) begin
			it = src_q.pop_front();
			drv_cp    <= it.cp;
			drv_last  <= it.last;
			drv_valid <= 1'b1;
			in_gap = idle_len(calm_in);
		end else begin
			drv_valid <= 1'b0;
		end
	end

	// Output backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			drv_ready <= 1'b0;
		end else if (out_stall > 0) begin
			drv_ready <= 1'b0;
			out_stall--;
		end else begin
			drv_ready <= 1'b1;
			out_stall = idle_len(calm_out);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : mon
		enc_char_t want;
		cyc++;
		if (cyc >= LIMIT_CYC) begin
			$display("url_percent_encoder regression: fail");
			$finish;
		end else begin
			in_hs = arst_n && in_bus.valid && in_bus.ready;
			// mode write drops any held surrogate
			if (arst_n && cfg_we) begin
				enc_mode      = cfg_wdata;
				enc_held      = 1'b0;
				enc_held_bits = '0;
			end
			if (in_hs)
				predict_run(in_bus.code_point, in_bus.last_in_string);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction: char %h last %b err %b",
						out_bus.out_char, out_bus.last_of_run, out_bus.encode_error));
				end else begin
					want = char_q.pop_front();
					if (out_bus.out_char !== want.ch)
						report_mismatch($sformatf("out_char: got %h want %h",
							out_bus.out_char, want.ch));
					if (out_bus.last_of_run !== want.run_end)
						report_mismatch($sformatf("last_of_run: got %b want %b (char %h)",
							out_bus.last_of_run, want.run_end, want.ch));
					if (out_bus.encode_error !== want.err)
						report_mismatch($sformatf("encode_error: got %b want %b (char %h)",
							out_bus.encode_error, want.err, want.ch));
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{
		MODE_SPACES, MODE_FORM, MODE_ESCAPE, MODE_URI_COMP, MODE_URI,
		MODE_UNDEF, MODE_URI_COMP, MODE_FORM, MODE_URI
	};

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed text in the reset mode (URI)
		queue_item(CP_W'("A"), 1'b0);
		queue_item(CP_W'("z"), 1'b0);
		queue_item(CP_W'("9"), 1'b0);
		queue_item(CP_W'("#"), 1'b0);
		queue_item(CH_SPACE, 1'b0);
		queue_item(21'h0, 1'b0);
		queue_item(21'h7F, 1'b0);
		queue_item(21'h80, 1'b0);
		queue_item(21'h7FF, 1'b0);
		queue_item(21'h800, 1'b0);
		queue_item(21'hFFFF, 1'b0);
		// surrogate pair, lowest and highest halves
		queue_item(SURR_LO, 1'b0);
		queue_item(SURR_HI_END, 1'b0);
		queue_item(21'hDBFF, 1'b0);
		queue_item(SURR_LAST, 1'b1);
		// lone low surrogate
		queue_item(SURR_HI_END, 1'b0);
		// held high surrogate followed by a plain letter
		queue_item(21'hD83D, 1'b0);
		queue_item(CP_W'("A"), 1'b0);
		// high surrogate closing the string
		queue_item(SURR_LO, 1'b1);
		queue_item(21'h10FFFF, 1'b0);
		queue_item(21'h110000, 1'b0);
		queue_item(21'h1FFFFF, 1'b1);
		// left held across the mode write below
		queue_item(21'hDBFF, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_wdata = phase_mode[p];
			@(negedge clk);
			cfg_we    = 1'b0;
			@(posedge clk);
			queue_random(PHASE_ITEMS);
		end

		settle();
		if (err_cnt == 0 && char_q.size() == 0) begin
			$display("url_percent_encoder regression: pass");
		end else begin
			$display("url_percent_encoder regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/upe_pkg.sv
hw/rtl/upe_ifs.sv
hw/rtl/upe_expand.sv
hw/rtl/url_percent_encoder.sv
test/tb_top.sv
